>>> hw/rtl/kf800_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf800_pkg
// Shared types, constants and the Keccak-f[800] round function.
// ----------------------------------------------------------------------------
package kf800_pkg;

    localparam int LANE_W      = 32;
    localparam int LANE_COUNT  = 25;
    localparam int ROUND_COUNT = 22;

    // item widths at the stream ports
    localparam int FIELD_W  = 64;
    localparam int IN_W     = 9 * FIELD_W;
    localparam int OUT_W    = 4 * FIELD_W;
    localparam int STATE_W  = LANE_COUNT * LANE_W;
    localparam int PAD_W    = STATE_W - IN_W;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [LANE_COUNT-1:0] state_t;

    localparam lane_t ROUND_CONST [24] = '{
        32'h00000001, 32'h00008082, 32'h0000808a, 32'h80008000, 32'h0000808b, 32'h80000001,
        32'h80008081, 32'h00008009, 32'h0000008a, 32'h00000088, 32'h80008009, 32'h8000000a,
        32'h8000808b, 32'h0000008b, 32'h00008089, 32'h00008003, 32'h00008002, 32'h00000080,
        32'h0000800a, 32'h8000000a, 32'h80008081, 32'h00008080, 32'h80000001, 32'h80008008
    };

    // standard keccak offsets, applied modulo the lane width
    localparam logic [5:0] RHO_OFFSET [24] = '{
        6'd1,  6'd3,  6'd6,  6'd10, 6'd15, 6'd21, 6'd28, 6'd36, 6'd45, 6'd55, 6'd2,  6'd14,
        6'd27, 6'd41, 6'd56, 6'd8,  6'd25, 6'd43, 6'd62, 6'd18, 6'd39, 6'd61, 6'd20, 6'd44
    };

    localparam logic [4:0] PI_LANE [24] = '{
        5'd10, 5'd7,  5'd11, 5'd17, 5'd18, 5'd3, 5'd5,  5'd16, 5'd8,  5'd21, 5'd24, 5'd4,
        5'd15, 5'd23, 5'd19, 5'd13, 5'd12, 5'd2, 5'd20, 5'd14, 5'd22, 5'd9,  5'd6,  5'd1
    };

    function automatic lane_t rotl(input lane_t x, input logic [4:0] n);
        lane_t r;
        if (n == 5'd0)
            r = x;
        else
            r = (x << n) | (x >> (6'd32 - {1'b0, n}));
        return r;
    endfunction

    // one full round: theta, rho-pi, chi, iota
    function automatic state_t keccak_round(input state_t s, input lane_t rc);
        lane_t  col [5];
        lane_t  d;
        state_t a;
        state_t b;
        state_t c;
        int     src;
        a = s;
        // theta
        for (int x = 0; x < 5; x++)
            col[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
        for (int x = 0; x < 5; x++)
        begin
            d = col[(x+4)%5] ^ rotl(col[(x+1)%5], 5'd1);
            for (int y = 0; y < 25; y += 5)
                a[y+x] = s[y+x] ^ d;
        end
        // rho and pi along the lane cycle starting at lane 1
        b   = a;
        src = 1;
        for (int k = 0; k < 24; k++)
        begin
            b[PI_LANE[k]] = rotl(a[src], RHO_OFFSET[k][4:0]);
            src           = int'(PI_LANE[k]);
        end
        // chi
        for (int y = 0; y < 25; y += 5)
            for (int x = 0; x < 5; x++)
                c[y+x] = b[y+x] ^ (~b[y+(x+1)%5] & b[y+(x+2)%5]);
        // iota
        c[0] = c[0] ^ rc;
        return c;
    endfunction

endpackage

>>> hw/rtl/kf800_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf800_cell
// One round of the chain: applies a round to the upstream state and holds
// the result until the downstream cell takes it.
// ----------------------------------------------------------------------------
module kf800_cell
    import kf800_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  lane_t  round_const,
    input  logic   in_valid,
    output logic   in_ready,
    input  state_t in_state,
    output logic   out_valid,
    input  logic   out_ready,
    output state_t out_state
);

    logic   valid_reg;
    logic   valid_next;
    state_t state_reg;

    // slot frees up when empty or when the held transaction moves on
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // round result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            state_reg <= keccak_round(in_state, round_const);
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

>>> hw/rtl/keccak_f800_sponge_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keccak_f800_sponge_hash
// Keccak-f[800] hash of header, seed and digest: a chain of 22 round cells.
// Each cell applies one round and registers its result for the next cell.
// Throughput: one transaction per cycle while m_tready is high, one round per cell.
// Bubbles collapse under output stalls; each cell holds one transaction.
// Reset: async active-low rst_n empties every cell; no other state is kept.
// ----------------------------------------------------------------------------
module keccak_f800_sponge_hash
    import kf800_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // header_w01, header_w23, header_w45, header_w67, seed_value,
    // digest_w01, digest_w23, digest_w45, digest_w67
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // hash_w01, hash_w23, hash_w45, hash_w67
    output logic [OUT_W-1:0] m_tdata
);

    state_t chain_state [ROUND_COUNT+1];
    logic   chain_valid [ROUND_COUNT+1];
    logic   chain_ready [ROUND_COUNT+1];

    // load: header lanes 0-7, seed lanes 8-9, digest lanes 10-17, rest zero
    assign chain_state[0] = state_t'({{PAD_W{1'b0}}, s_tdata});
    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    // round cells
    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_cell
        kf800_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .round_const (ROUND_CONST[r]),
            .in_valid    (chain_valid[r]),
            .in_ready    (chain_ready[r]),
            .in_state    (chain_state[r]),
            .out_valid   (chain_valid[r+1]),
            .out_ready   (chain_ready[r+1]),
            .out_state   (chain_state[r+1])
        );
    end

    // last cell doubles as the output register
    assign chain_ready[ROUND_COUNT] = m_tready;
    assign m_tvalid = chain_valid[ROUND_COUNT];
    assign m_tdata  = chain_state[ROUND_COUNT][7:0];

endmodule
